// ===== hdl/twd_pkg.sv =====
// ----------------------------------------------------------------------------
// twd_pkg: shared types and constants of the trie word dictionary
// Field widths, letter encoding and the beat payloads of both channels.
// ----------------------------------------------------------------------------
package twd_pkg;

	localparam int NODE_COUNT_DEF = 1024;
	localparam int ALPHABET_DEF   = 26;

	localparam int CHAR_W       = 7;
	localparam int NODES_USED_W = 11;

	localparam logic [CHAR_W-1:0] LETTER_BASE = 7'd97;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_POOL_OUT = 1'b1;

	typedef struct packed {
		logic              command;
		logic [CHAR_W-1:0] char_code;
		logic              first_letter;
		logic              last_letter;
	} letter_beat_t;

	typedef struct packed {
		logic                    found;
		logic                    status;
		logic [NODES_USED_W-1:0] nodes_used;
	} result_beat_t;

endpackage

// ===== hdl/twd_stream_if.sv =====
// ----------------------------------------------------------------------------
// twd_stream_if: valid/ready channel
// Carries one payload beat per handshake; source drives valid and payload.
// ----------------------------------------------------------------------------
interface twd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/twd_ram.sv =====
// ----------------------------------------------------------------------------
// twd_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module twd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ===== hdl/trie_word_dictionary_unit.sv =====
// ----------------------------------------------------------------------------
// trie_word_dictionary_unit: dictionary trie over a node table
// Insert and search of lowercase words, one letter per beat, with a bump
// allocator for new nodes and a result beat at the end of each word.
// ----------------------------------------------------------------------------
// Letter flow: a letter that walks is accepted in IDLE with its link read,
//   then LINK checks the link and optionally writes it; one that does not
//   walk is taken in IDLE alone. A word's last letter then goes to MARK, to
//   MKRD for a search that found its link, and to OUT, which offers the
//   result beat once the output slot is free. Letters are taken only in IDLE.
// Reset: arst_n clears the walk state, then a clearing pass over every link
//   address zeroes the link and mark RAMs; no letter is accepted during the pass.
module trie_word_dictionary_unit #(
	parameter int NODE_COUNT = twd_pkg::NODE_COUNT_DEF,
	parameter int ALPHABET   = twd_pkg::ALPHABET_DEF
) (
	input logic   clk,
	input logic   arst_n,
	twd_stream_if.sink   letters,
	twd_stream_if.source results
);
	import twd_pkg::*;

	localparam int NW = $clog2(NODE_COUNT);            // node index width
	localparam int CW = $clog2(NODE_COUNT + 1);        // pool count width
	localparam int LINK_DEPTH = NODE_COUNT * ALPHABET;
	localparam int AW = $clog2(LINK_DEPTH);            // link address width
	localparam int LW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_LINK  = 3'd2;
	localparam logic [2:0] ST_MARK  = 3'd3;
	localparam logic [2:0] ST_MKRD  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	// sequencer and walk state
	logic [2:0]    state_q;
	logic [NW-1:0] node_q;
	logic [CW-1:0] free_q;
	logic          miss_q;
	logic          ovf_q;
	logic [AW-1:0] clr_q;
	logic          out_valid_q;

	// letter held while it is worked on
	logic          cmd_q;
	logic          last_q;
	logic [AW-1:0] addr_q;
	logic          res_found_q;
	logic          res_status_q;
	result_beat_t  out_beat_q;

	// accept-side decode
	letter_beat_t  beat;
	logic          accept;
	logic [CHAR_W-1:0] char_off;
	logic          letter_ok;
	logic [LW-1:0] letter;
	logic [NW-1:0] eff_node;
	logic          eff_walk;
	logic [AW-1:0] look_addr;

	// RAM ports
	logic          link_we;
	logic [AW-1:0] link_waddr;
	logic [NW-1:0] link_wdata;
	logic          link_re;
	logic [NW-1:0] link_rdata;
	logic          mark_we;
	logic [NW-1:0] mark_waddr;
	logic          mark_wdata;
	logic          mark_re;
	logic          mark_rdata;
	logic          clr_last;
	logic          clr_in_marks;
	logic          pool_left;
	logic          out_free;

	assign beat     = letters.payload;
	assign accept   = letters.valid && letters.ready;
	assign letters.ready = (state_q == ST_IDLE);

	assign char_off  = beat.char_code - LETTER_BASE;
	assign letter_ok = (beat.char_code >= LETTER_BASE) &&
		({1'b0, beat.char_code} < ({1'b0, LETTER_BASE} + (CHAR_W+1)'(ALPHABET)));
	assign letter    = char_off[LW-1:0];

	// first letter restarts the walk at the root with flags clear
	assign eff_node  = beat.first_letter ? '0 : node_q;
	assign eff_walk  = beat.first_letter || (!miss_q && !ovf_q);
	assign look_addr = AW'(eff_node) * AW'(ALPHABET) + AW'(letter);

	assign clr_last     = (clr_q == AW'(LINK_DEPTH - 1));
	assign clr_in_marks = ({1'b0, clr_q} < (AW+1)'(NODE_COUNT));
	assign pool_left    = (free_q < CW'(NODE_COUNT));
	assign out_free     = !out_valid_q || results.ready;

	assign results.valid   = out_valid_q;
	assign results.payload = out_beat_q;

	// drive the RAM ports: clearing pass, link lookup and allocation, word-end marking and mark read
	always_comb begin
		link_we    = 1'b0;
		link_waddr = addr_q;
		link_wdata = free_q[NW-1:0];
		link_re    = 1'b0;
		mark_we    = 1'b0;
		mark_waddr = node_q;
		mark_wdata = 1'b1;
		mark_re    = 1'b0;
		unique case (state_q) inside
			ST_CLEAR: begin
				link_we    = 1'b1;
				link_waddr = clr_q;
				link_wdata = '0;
				mark_we    = clr_in_marks;
				mark_waddr = clr_q[NW-1:0];
				mark_wdata = 1'b0;
			end
			ST_IDLE: begin
				link_re = accept && eff_walk && letter_ok;
			end
			ST_LINK: begin
				link_we = (link_rdata == '0) && (cmd_q == CMD_INSERT) && pool_left;
			end
			ST_MARK: begin
				mark_we = (cmd_q == CMD_INSERT) && !miss_q && !ovf_q;
				mark_re = (cmd_q == CMD_SEARCH) && !miss_q && !ovf_q;
			end
			ST_MKRD, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			node_q      <= '0;
			free_q      <= CW'(1);
			miss_q      <= 1'b0;
			ovf_q       <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load the output slot, or drop the beat once it is taken
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						node_q <= eff_node;
						ovf_q  <= beat.first_letter ? 1'b0 : ovf_q;
						if (eff_walk && letter_ok) begin
							miss_q  <= beat.first_letter ? 1'b0 : miss_q;
							state_q <= ST_LINK;
						end else begin
							// a bad letter breaks a search path; an insert skips it
							miss_q  <= (eff_walk && beat.command == CMD_SEARCH) ||
								(!beat.first_letter && miss_q);
							state_q <= beat.last_letter ? ST_MARK : ST_IDLE;
						end
					end
				end
				ST_LINK: begin
					if (link_rdata != '0) begin
						node_q <= link_rdata;
					end else if (cmd_q == CMD_SEARCH) begin
						miss_q <= 1'b1;
					end else if (pool_left) begin
						node_q <= free_q[NW-1:0];
						free_q <= free_q + CW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					state_q <= last_q ? ST_MARK : ST_IDLE;
				end
				ST_MARK: begin
					// end of word: return to the root
					node_q  <= '0;
					miss_q  <= 1'b0;
					ovf_q   <= 1'b0;
					state_q <= mark_re ? ST_MKRD : ST_OUT;
				end
				ST_MKRD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload held for the letter and the result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= beat.command;
			last_q <= beat.last_letter;
			addr_q <= look_addr;
		end
		if (state_q == ST_MARK) begin
			if (cmd_q == CMD_INSERT) begin
				res_found_q  <= !miss_q && !ovf_q;
				res_status_q <= ovf_q ? STATUS_POOL_OUT : STATUS_OK;
			end else begin
				res_found_q  <= 1'b0;
				res_status_q <= STATUS_OK;
			end
		end
		if (state_q == ST_MKRD) begin
			res_found_q <= mark_rdata;
		end
		if (state_q == ST_OUT && out_free) begin
			out_beat_q.found      <= res_found_q;
			out_beat_q.status     <= res_status_q;
			out_beat_q.nodes_used <= NODES_USED_W'(free_q);
		end
	end

	twd_ram #(
		.WIDTH (NW),
		.DEPTH (LINK_DEPTH)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (link_we),
		.wr_addr (link_waddr),
		.wr_data (link_wdata),
		.rd_en   (link_re),
		.rd_addr (look_addr),
		.rd_data (link_rdata)
	);

	twd_ram #(
		.WIDTH (1),
		.DEPTH (NODE_COUNT)
	) u_mark_ram (
		.clk     (clk),
		.wr_en   (mark_we),
		.wr_addr (mark_waddr),
		.wr_data (mark_wdata),
		.rd_en   (mark_re),
		.rd_addr (node_q),
		.rd_data (mark_rdata)
	);

endmodule
